FILE: rtl/cfpd_pkg.sv
// Shared constants, register indexes and helpers for the protection debounce block.
package cfpd_pkg;

  localparam int unsigned TIMER_BITS = 8;
  localparam int unsigned CFG_W      = 8;
  localparam int unsigned CFG_IDX_W  = 3;

  typedef logic [TIMER_BITS-1:0] timer_t;
  typedef logic [CFG_W-1:0]      cfg_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CL_DEB   = 3'd0,
    REG_HR_CV    = 3'd1,
    REG_HR_CC    = 3'd2,
    REG_OFF_DEB  = 3'd3,
    REG_OTP_TRIP = 3'd4,
    REG_OTP_REL  = 3'd5,
    REG_OPT      = 3'd6
  } cfg_idx_e;

  localparam timer_t TimerZero = timer_t'(0);
  localparam timer_t TimerOne  = timer_t'(1);

  // Fit an 8-bit register value to the timer width
  function automatic timer_t to_timer(cfg_t v);
    logic [TIMER_BITS+CFG_W-1:0] ext;
    ext = {{TIMER_BITS{1'b0}}, v};
    return ext[TIMER_BITS-1:0];
  endfunction

endpackage

FILE: rtl/charger_fault_protection_debounce.sv
// Top level of the charger fault protection debounce block.
//
//   channel  | valid        | stall         | payload
//   ---------+--------------+---------------+----------------------------------
//   request  | in_valid_i   | in_stall_o    | func_i .. timer_step_i
//   result   | out_valid_o  | out_stall_i   | cl_limit_o .. otp_active_o
//   config   | cfg_we_i     | (none)        | cfg_idx_i, cfg_wdata_i
//
// One request per cycle unless stalled: the state update and the result are
// computed in the cycle of acceptance and reach the output register next cycle.
// A request is stalled only while a result is held and the result side stalls.
// Reset clears the debounce state; the fault-to-off timer comes up at one.
module charger_fault_protection_debounce (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cfpd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cfpd_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        func_i,
  input  logic                        cl_val_i,
  input  logic                        ocp_en_i,
  input  logic                        ocp_val_i,
  input  logic                        under_2v8_i,
  input  logic [7:0]                  temp_code_i,
  input  logic                        scp_val_i,
  input  logic                        ovp_fault_i,
  input  logic                        uvp_val_i,
  input  logic                        pps_active_i,
  input  logic                        discharge_i,
  input  logic                        timer_step_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        cl_limit_o,
  output logic                        cl_changed_o,
  output logic                        fault_hard_reset_o,
  output logic                        fault_off_o,
  output logic                        vbus_off_now_o,
  output logic                        otp_active_o
);
  import cfpd_pkg::*;

  cfg_t       cl_deb_q, hr_cv_q, hr_cc_q, off_deb_q, otp_trip_q, otp_rel_q;
  logic [3:0] opt_q;

  logic   cl_sample_q, cl_status_q, hr_signal_q, otp_signal_q, hr_latched_q;
  logic   off_signal_q, off_latched_q;
  timer_t cl_timer_q, hr_timer_q, off_timer_q;

  logic   cl_sample_d, cl_status_d, hr_signal_d, otp_signal_d, hr_latched_d;
  logic   off_signal_d, off_latched_d;
  timer_t cl_timer_d, hr_timer_d, off_timer_d;
  logic   changed_d;

  logic   out_valid_q;
  logic   cl_limit_q, cl_changed_q, fault_hr_q, fault_off_q, vbus_off_q, otp_q;

  logic   in_acc;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cl_deb_q   <= 8'd16;
      hr_cv_q    <= 8'd32;
      hr_cc_q    <= 8'd32;
      off_deb_q  <= 8'd16;
      otp_trip_q <= 8'd64;
      otp_rel_q  <= 8'd80;
      opt_q      <= 4'hF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CL_DEB:   cl_deb_q   <= cfg_wdata_i;
        REG_HR_CV:    hr_cv_q    <= cfg_wdata_i;
        REG_HR_CC:    hr_cc_q    <= cfg_wdata_i;
        REG_OFF_DEB:  off_deb_q  <= cfg_wdata_i;
        REG_OTP_TRIP: otp_trip_q <= cfg_wdata_i;
        REG_OTP_REL:  otp_rel_q  <= cfg_wdata_i;
        REG_OPT:      opt_q      <= cfg_wdata_i[3:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    timer_t ld_cl, ld_cv, ld_cc, ld_off, mode_len, cl_dec;
    logic   fast_fault;
    ld_cl  = to_timer(cl_deb_q);
    ld_cv  = to_timer(hr_cv_q);
    ld_cc  = to_timer(hr_cc_q);
    ld_off = to_timer(off_deb_q);

    cl_sample_d   = cl_sample_q;
    cl_status_d   = cl_status_q;
    cl_timer_d    = cl_timer_q;
    hr_signal_d   = hr_signal_q;
    otp_signal_d  = otp_signal_q;
    hr_latched_d  = hr_latched_q;
    hr_timer_d    = hr_timer_q;
    off_signal_d  = off_signal_q;
    off_latched_d = off_latched_q;
    off_timer_d   = off_timer_q;
    changed_d     = 1'b0;
    mode_len      = ocp_en_i ? ld_cv : ld_cc;
    cl_dec        = cl_timer_q - TimerOne;
    fast_fault    = (opt_q[1] && scp_val_i) || (opt_q[2] && ovp_fault_i);

    if (func_i) begin
      off_timer_d   = ld_off;
      off_signal_d  = 1'b0;
      off_latched_d = 1'b1;
    end else begin
      // current limit: reload on a sample change, count down while stable
      cl_sample_d = cl_val_i;
      if (cl_sample_q == cl_val_i) begin
        if (cl_timer_q != TimerZero) begin
          cl_timer_d = cl_dec;
          if (cl_dec == TimerZero && cl_status_q != cl_val_i && !hr_latched_q) begin
            changed_d   = 1'b1;
            cl_status_d = cl_val_i;
            if (hr_timer_q != TimerZero) hr_timer_d = ld_cv;
          end
        end
      end else begin
        cl_timer_d = ld_cl;
      end

      // fault to hard reset
      if (timer_step_i) begin
        hr_signal_d = 1'b0;
      end else begin
        if (otp_signal_q && hr_latched_q) begin
          otp_signal_d = opt_q[0] && (temp_code_i <= otp_rel_q);
        end else begin
          otp_signal_d = opt_q[0] && (temp_code_i < otp_trip_q);
        end
        hr_signal_d = (ocp_en_i ? ocp_val_i : (under_2v8_i && cl_status_d)) || otp_signal_d;
      end
      if (hr_timer_d != TimerZero) begin
        if (ocp_en_i && discharge_i) begin
          hr_timer_d = ld_cv;
        end else if (hr_signal_d) begin
          hr_timer_d = hr_timer_d - TimerOne;
          if (hr_timer_d == TimerZero) hr_latched_d = 1'b1;
        end else if (hr_timer_d >= mode_len) begin
          hr_timer_d   = TimerZero;
          hr_latched_d = 1'b0;
        end else begin
          hr_timer_d = hr_timer_d + TimerOne;
        end
      end else if (hr_signal_q != hr_signal_d) begin
        hr_timer_d = hr_signal_d ? mode_len : TimerOne;
      end

      // fault to off: latch a rising fast fault at once, debounce the rest
      off_signal_d = (opt_q[3] && uvp_val_i && !pps_active_i) || fast_fault;
      if (off_signal_q == off_signal_d) begin
        if (off_timer_q != TimerZero) begin
          off_timer_d = off_timer_q - TimerOne;
          if (off_timer_d == TimerZero) off_latched_d = off_signal_d;
        end
      end else if (!fast_fault || off_latched_q) begin
        off_timer_d = ld_off;
      end else begin
        off_latched_d = off_signal_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cl_sample_q   <= 1'b0;
      cl_status_q   <= 1'b0;
      cl_timer_q    <= TimerZero;
      hr_signal_q   <= 1'b0;
      otp_signal_q  <= 1'b0;
      hr_latched_q  <= 1'b0;
      hr_timer_q    <= TimerZero;
      off_signal_q  <= 1'b0;
      off_latched_q <= 1'b0;
      off_timer_q   <= TimerOne;
    end else if (in_acc) begin
      cl_sample_q   <= cl_sample_d;
      cl_status_q   <= cl_status_d;
      cl_timer_q    <= cl_timer_d;
      hr_signal_q   <= hr_signal_d;
      otp_signal_q  <= otp_signal_d;
      hr_latched_q  <= hr_latched_d;
      hr_timer_q    <= hr_timer_d;
      off_signal_q  <= off_signal_d;
      off_latched_q <= off_latched_d;
      off_timer_q   <= off_timer_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload: load on every accepted request
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cl_limit_q   <= cl_status_d;
      cl_changed_q <= changed_d;
      fault_hr_q   <= hr_latched_d;
      fault_off_q  <= off_latched_d;
      vbus_off_q   <= func_i;
      otp_q        <= otp_signal_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign cl_limit_o         = cl_limit_q;
  assign cl_changed_o       = cl_changed_q;
  assign fault_hard_reset_o = fault_hr_q;
  assign fault_off_o        = fault_off_q;
  assign vbus_off_now_o     = vbus_off_q;
  assign otp_active_o       = otp_q;

endmodule

FILE: rtl/cfpd_checker.sv
// Port-level checker for the protection debounce block, with its bind.
module cfpd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic cl_changed_o,
  input logic fault_off_o,
  input logic vbus_off_now_o
);

  // A held result must stay offered while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  // Requests are stalled only behind a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("request stalled with no waiting result");

  // Every accepted request yields a result next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted request gave no result");

  // A fault interrupt forces fault-to-off and never reports a limit change
  a_irq_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && vbus_off_now_o) |-> (fault_off_o && !cl_changed_o))
    else $error("fault interrupt result inconsistent");

endmodule

bind charger_fault_protection_debounce cfpd_checker u_cfpd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .cl_changed_o   (cl_changed_o),
  .fault_off_o    (fault_off_o),
  .vbus_off_now_o (vbus_off_now_o)
);

FILE: tb/sv/tb.sv
// Self-checking testbench for the charger fault protection debounce block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cfpd_pkg::*;

  localparam int OPT_OTP = 0;
  localparam int OPT_SCP = 1;
  localparam int OPT_OVP = 2;
  localparam int OPT_UVP = 3;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned PHASE_ITEMS  = 150;
  localparam int unsigned MAX_REPORTED = 10;

  typedef struct packed {
    logic       func, cl_val, ocp_en, ocp_val, under_2v8;
    logic [7:0] temp_code;
    logic       scp_val, ovp_fault, uvp_val, pps_active, discharge, timer_step;
  } prot_req_t;

  typedef struct packed {
    logic cl_limit, cl_changed, fault_hard_reset, fault_off, vbus_off_now, otp_active;
  } prot_rsp_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = REG_CL_DEB;
  cfg_t                 cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  prot_req_t            req_bus     = '0;
  logic                 out_stall_i = 1'b0;
  logic in_stall_o, out_valid_o;
  logic cl_limit_o, cl_changed_o, fault_hard_reset_o, fault_off_o, vbus_off_now_o, otp_active_o;

  charger_fault_protection_debounce i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .func_i             (req_bus.func),
    .cl_val_i           (req_bus.cl_val),
    .ocp_en_i           (req_bus.ocp_en),
    .ocp_val_i          (req_bus.ocp_val),
    .under_2v8_i        (req_bus.under_2v8),
    .temp_code_i        (req_bus.temp_code),
    .scp_val_i          (req_bus.scp_val),
    .ovp_fault_i        (req_bus.ovp_fault),
    .uvp_val_i          (req_bus.uvp_val),
    .pps_active_i       (req_bus.pps_active),
    .discharge_i        (req_bus.discharge),
    .timer_step_i       (req_bus.timer_step),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .cl_limit_o         (cl_limit_o),
    .cl_changed_o       (cl_changed_o),
    .fault_hard_reset_o (fault_hard_reset_o),
    .fault_off_o        (fault_off_o),
    .vbus_off_now_o     (vbus_off_now_o),
    .otp_active_o       (otp_active_o)
  );

  always #10 clk_i = ~clk_i;

  // Shadow registers and protection state
  timer_t     cfg_lim_len, cfg_cv_len, cfg_cc_len, cfg_off_len;
  cfg_t       cfg_trip, cfg_rel;
  logic [3:0] cfg_opt;
  logic       lim_smp, lim_stat, hr_cond, ot_flag, hr_flag, off_cond, off_flag;
  timer_t     lim_cnt, hr_cnt, off_cnt;

  prot_rsp_t   pending_verdicts[$];
  int unsigned requests_sent, verdicts_checked, mismatches, stray_results, settings_used;
  int unsigned lim_changes, hr_trips, off_trips;
  bit          tx_idle_on, rx_idle_on, hold_req;
  int unsigned stall_left;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic prot_rsp_t qualify_faults(prot_req_t r);
    prot_rsp_t v;
    logic      prev, any_fault, was_hr, was_off;
    timer_t    mode_len;
    v       = '0;
    was_hr  = hr_flag;
    was_off = off_flag;
    if (r.func) begin
      off_cnt        = cfg_off_len;
      off_cond       = 1'b0;
      off_flag       = 1'b1;
      v.vbus_off_now = 1'b1;
    end else begin
      // current limit: sample must hold for the full debounce count
      prev    = lim_smp;
      lim_smp = r.cl_val;
      if (prev == lim_smp) begin
        if (lim_cnt != TimerZero) begin
          lim_cnt = lim_cnt - TimerOne;
          if (lim_cnt == TimerZero && lim_stat != lim_smp && !hr_flag) begin
            v.cl_changed = 1'b1;
            lim_stat     = lim_smp;
            if (hr_cnt != TimerZero) hr_cnt = cfg_cv_len;
          end
        end
      end else begin
        lim_cnt = cfg_lim_len;
      end

      // hard-reset condition with over-temperature hysteresis
      prev = hr_cond;
      if (r.timer_step) begin
        hr_cond = 1'b0;
      end else begin
        if (ot_flag && hr_flag) ot_flag = cfg_opt[OPT_OTP] && (r.temp_code <= cfg_rel);
        else                    ot_flag = cfg_opt[OPT_OTP] && (r.temp_code < cfg_trip);
        hr_cond = (r.ocp_en ? r.ocp_val : (r.under_2v8 && lim_stat)) || ot_flag;
      end
      mode_len = r.ocp_en ? cfg_cv_len : cfg_cc_len;
      if (hr_cnt != TimerZero) begin
        if (r.ocp_en && r.discharge) begin
          hr_cnt = cfg_cv_len;
        end else if (hr_cond) begin
          hr_cnt = hr_cnt - TimerOne;
          if (hr_cnt == TimerZero) hr_flag = 1'b1;
        end else if (hr_cnt >= mode_len) begin
          hr_cnt  = TimerZero;
          hr_flag = 1'b0;
        end else begin
          hr_cnt = hr_cnt + TimerOne;
        end
      end else if (prev != hr_cond) begin
        hr_cnt = hr_cond ? mode_len : TimerOne;
      end

      // fault to off: latch a rising fast fault at once, debounce the rest
      prev      = off_cond;
      any_fault = (cfg_opt[OPT_SCP] && r.scp_val) || (cfg_opt[OPT_OVP] && r.ovp_fault);
      off_cond  = (cfg_opt[OPT_UVP] && r.uvp_val && !r.pps_active) || any_fault;
      if (prev == off_cond) begin
        if (off_cnt != TimerZero) begin
          off_cnt = off_cnt - TimerOne;
          if (off_cnt == TimerZero) off_flag = off_cond;
        end
      end else if (!any_fault || off_flag) begin
        off_cnt = cfg_off_len;
      end else begin
        off_flag = off_cond;
      end
    end
    v.cl_limit         = lim_stat;
    v.fault_hard_reset = hr_flag;
    v.fault_off        = off_flag;
    v.otp_active       = ot_flag;
    lim_changes += 32'(v.cl_changed);
    hr_trips    += 32'(hr_flag && !was_hr);
    off_trips   += 32'(off_flag && !was_off);
    return v;
  endfunction

  function automatic prot_req_t quiet_tick();
    prot_req_t r;
    r           = '0;
    r.temp_code = 8'hFF;
    return r;
  endfunction

  function automatic prot_req_t random_tick(bit allow_event);
    prot_req_t r;
    r = prot_req_t'({$urandom, $urandom});
    r.func = allow_event && ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 5))
      0:       r.temp_code = cfg_trip - 8'd1;
      1:       r.temp_code = cfg_trip;
      2:       r.temp_code = cfg_rel;
      3:       r.temp_code = cfg_rel + 8'd1;
      4:       r.temp_code = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: r.temp_code = 8'($urandom_range(0, 255));
    endcase
    return r;
  endfunction

  task automatic pause_sender();
    int unsigned n;
    n = tx_idle_on ? pick_gap() : 0;
    if (n != 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic offer_request(input prot_req_t r);
    req_bus    <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_verdicts.push_back(qualify_faults(r));
    requests_sent++;
    pause_sender();
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic program_reg(input cfg_idx_e idx, input cfg_t val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_CL_DEB:   cfg_lim_len = to_timer(val);
      REG_HR_CV:    cfg_cv_len  = to_timer(val);
      REG_HR_CC:    cfg_cc_len  = to_timer(val);
      REG_OFF_DEB:  cfg_off_len = to_timer(val);
      REG_OTP_TRIP: cfg_trip    = val;
      REG_OTP_REL:  cfg_rel     = val;
      REG_OPT:      cfg_opt     = val[3:0];
      default: ;
    endcase
  endtask

  task automatic program_all(input cfg_t lim, input cfg_t cv, input cfg_t cc, input cfg_t off,
                             input cfg_t trip, input cfg_t rel, input logic [3:0] opt);
    program_reg(REG_CL_DEB, lim);
    program_reg(REG_HR_CV, cv);
    program_reg(REG_HR_CC, cc);
    program_reg(REG_OFF_DEB, off);
    program_reg(REG_OTP_TRIP, trip);
    program_reg(REG_OTP_REL, rel);
    program_reg(REG_OPT, cfg_t'(opt));
    settings_used++;
  endtask

  // Stable runs with random content, salted with glitches and fault events
  task automatic run_sequences(input int unsigned budget);
    prot_req_t   base;
    int unsigned sent, run_len, span, r;
    span = 32'(cfg_lim_len);
    if (32'(cfg_cv_len) > span)  span = 32'(cfg_cv_len);
    if (32'(cfg_cc_len) > span)  span = 32'(cfg_cc_len);
    if (32'(cfg_off_len) > span) span = 32'(cfg_off_len);
    if (span == 0) span = 1;
    sent = 0;
    while (sent < budget) begin
      base = random_tick(1'b0);
      r    = $urandom_range(0, 99);
      if (r < 55)      run_len = $urandom_range(1, 4);
      else if (r < 85) run_len = $urandom_range(span, span + 3);
      else             run_len = $urandom_range(1, 2 * span + 2);
      if (run_len > budget - sent) run_len = budget - sent;
      repeat (run_len) begin
        if ($urandom_range(0, 9) == 0) offer_request(random_tick(1'b1));
        else                           offer_request(base);
        sent++;
      end
    end
  endtask

  task automatic test_directed();
    prot_req_t r;
    r = quiet_tick();
    offer_request(r);
    r.func = 1'b1;
    offer_request(r);
    drain_results();
    program_all(8'd2, 8'd3, 8'd4, 8'd2, 8'd64, 8'd80, 4'hF);
    r = quiet_tick();
    r.cl_val = 1'b1;
    repeat (4) offer_request(r);
    r.under_2v8 = 1'b1;
    repeat (6) offer_request(r);
    // limit change must be held off while the hard reset is latched
    r.cl_val = 1'b0;
    repeat (3) offer_request(r);
    r.temp_code = 8'd0;
    offer_request(r);
    r.temp_code = 8'd80;
    offer_request(r);
    r.temp_code = 8'd81;
    offer_request(r);
    r.timer_step = 1'b1;
    offer_request(r);
    r = quiet_tick();
    r.ocp_en    = 1'b1;
    r.ocp_val   = 1'b1;
    r.discharge = 1'b1;
    offer_request(r);
    r = quiet_tick();
    r.scp_val = 1'b1;
    offer_request(r);
    r.scp_val    = 1'b0;
    r.ovp_fault  = 1'b1;
    r.uvp_val    = 1'b1;
    r.pps_active = 1'b1;
    offer_request(r);
    r      = '1;
    r.func = 1'b0;
    offer_request(r);
    r.func = 1'b1;
    offer_request(r);
    drain_results();
  endtask

  task automatic test_zero_length();
    prot_req_t r;
    program_all(8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 4'hF);
    r = quiet_tick();
    r.under_2v8 = 1'b1;
    for (int i = 0; i < 8; i++) begin
      r.cl_val    = i[1];
      r.scp_val   = i[0];
      r.temp_code = 8'(i * 37);
      offer_request(r);
    end
    drain_results();
  endtask

  task automatic test_register_sweep();
    for (int p = 0; p < 9; p++) begin
      tx_idle_on = (p % 3 != 1);
      rx_idle_on = (p % 3 != 2);
      case (p)
        0: program_all(8'd16, 8'd32, 8'd32, 8'd16, 8'd64, 8'd80, 4'hF);
        1: program_all(8'd1, 8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 4'h0);
        2: program_all(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 4'hF);
        3: program_all(8'd1, 8'd1, 8'd1, 8'd1, 8'd255, 8'd0, 4'hF);
        default: program_all(8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)),
                             8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             4'($urandom_range(0, 15)));
      endcase
      run_sequences(p == 2 ? 400 : PHASE_ITEMS);
      drain_results();
    end
  endtask

  task automatic test_output_hold();
    program_all(8'd3, 8'd4, 8'd5, 8'd3, 8'd100, 8'd120, 4'hF);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    hold_req   = 1'b1;
    run_sequences(80);
    drain_results();
    tx_idle_on = 1'b1;
  endtask

  // Receiver: random stalls, or one long hold-off when asked
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req   = 1'b0;
      stall_left = HOLD_CYCLES;
    end else if (stall_left == 0 && rx_idle_on && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
    end
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_results
    prot_rsp_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {cl_limit_o, cl_changed_o, fault_hard_reset_o, fault_off_o, vbus_off_now_o,
             otp_active_o};
      if (pending_verdicts.size() == 0) begin
        stray_results++;
        if (mismatches + stray_results <= MAX_REPORTED)
          $display("%0t: result with no request outstanding", $realtime);
      end else begin
        want = pending_verdicts.pop_front();
        verdicts_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches + stray_results <= MAX_REPORTED)
            $display("%0t: result %0d lim/chg/hr/off/vbus/otp expected %b%b%b%b%b%b got %b%b%b%b%b%b",
                     $realtime, verdicts_checked, want.cl_limit, want.cl_changed,
                     want.fault_hard_reset, want.fault_off, want.vbus_off_now, want.otp_active,
                     got.cl_limit, got.cl_changed, got.fault_hard_reset, got.fault_off,
                     got.vbus_off_now, got.otp_active);
        end
      end
    end
  end

  initial begin
    cfg_lim_len = 8'd16; cfg_cv_len = 8'd32; cfg_cc_len = 8'd32; cfg_off_len = 8'd16;
    cfg_trip    = 8'd64; cfg_rel    = 8'd80; cfg_opt    = 4'hF;
    lim_smp  = 1'b0; lim_stat = 1'b0; lim_cnt = TimerZero;
    hr_cond  = 1'b0; ot_flag  = 1'b0; hr_flag = 1'b0; hr_cnt = TimerZero;
    off_cond = 1'b0; off_flag = 1'b0; off_cnt = TimerOne;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  end

  initial begin
    int unsigned waited;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_zero_length();
    test_register_sweep();
    test_output_hold();
    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_verdicts.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
    $display("Sent %0d requests across %0d register settings, checked %0d results.",
             requests_sent, settings_used, verdicts_checked);
    $display("Seen %0d limit changes, %0d hard-reset trips, %0d fault-off trips.",
             lim_changes, hr_trips, off_trips);
    if (mismatches == 0 && stray_results == 0 && pending_verdicts.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d stray results, %0d results missing",
               mismatches, stray_results, pending_verdicts.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d results outstanding", pending_verdicts.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: files.f
rtl/cfpd_pkg.sv
rtl/charger_fault_protection_debounce.sv
rtl/cfpd_checker.sv
tb/sv/tb.sv
